[rtl/core/sen_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sen_pkg
// Shared types and constants of the sample entropy engine.
// ----------------------------------------------------------------------------
package sen_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int MAX_ORDER_DEF   = 8;
    localparam int FRAC_BITS       = 20;
    localparam int MANT_W          = 31;               // Q1.30 mantissa
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    localparam logic [2:0]  EMBED_ORDER_RST = 3'd1;
    localparam logic [14:0] TOLERANCE_RST   = 15'd1229;

    typedef enum logic {
        REG_EMBED_ORDER = 1'b0,
        REG_TOLERANCE   = 1'b1
    } sen_reg_idx_t;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_sample;
    } sen_in_t;

    typedef struct packed {
        logic [2:0]  order_index;
        logic [18:0] match_total;
        logic [18:0] template_total;
        logic [19:0] entropy_value;
        logic        undefined_flag;
        logic        last_result;
    } sen_out_t;

endpackage
`default_nettype wire

[rtl/core/sen_log_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sen_log_unit
// Iterative log2 in Q.20: shift-normalize one bit a cycle, then one
// squaring step per fraction bit.
// ----------------------------------------------------------------------------
module sen_log_unit
    import sen_pkg::*;
#(
    parameter int CNT_W = 19,
    parameter int EW    = 5
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [CNT_W-1:0]        x,
    output logic                         done,
    output logic [EW+FRAC_BITS-1:0]      result
);

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_NORM = 3'b010,
        L_SQ   = 3'b100
    } lg_state_t;

    localparam int K_W = $clog2(FRAC_BITS);

    lg_state_t              state_reg, state_next;
    logic [MANT_W-1:0]      sh_reg;
    logic [EW-1:0]          e_reg;
    logic [FRAC_BITS-1:0]   frac_reg;
    logic [K_W-1:0]         k_reg;
    logic                   done_reg;
    logic [2*MANT_W-1:0]    sq;
    logic [MANT_W-1:0]      sq_m;

    assign sq     = {{MANT_W{1'b0}}, sh_reg} * {{MANT_W{1'b0}}, sh_reg};
    // m*m >> 30; renormalize when the square reaches 2.0
    assign sq_m   = sq[2*MANT_W-1] ? sq[2*MANT_W-1:MANT_W] : sq[2*MANT_W-2:MANT_W-1];
    assign done   = done_reg;
    assign result = {e_reg, frac_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            L_IDLE: if (start) state_next = L_NORM;
            L_NORM: if (sh_reg[MANT_W-1]) state_next = L_SQ;
            L_SQ:   if (k_reg == '0) state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == L_SQ) && (k_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            L_IDLE: begin
                sh_reg   <= {x, {(MANT_W-CNT_W){1'b0}}};
                e_reg    <= EW'(CNT_W-1);
                frac_reg <= '0;
                k_reg    <= K_W'(FRAC_BITS-1);
            end
            L_NORM: begin
                if (!sh_reg[MANT_W-1]) begin
                    sh_reg <= {sh_reg[MANT_W-2:0], 1'b0};
                    e_reg  <= e_reg - 1'b1;
                end
            end
            L_SQ: begin
                sh_reg   <= sq_m;
                frac_reg <= {frac_reg[FRAC_BITS-2:0], sq[2*MANT_W-1]};
                k_reg    <= k_reg - 1'b1;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/sample_entropy_engine_unit.sv]
`default_nettype none
// Load: one word a cycle; s_ready stays high until the word with last_sample.
// Pair pass: one pair per cycle through one compare unit, set by the
// single read port of the sample store.
// Results: each defined result takes two serial log2 runs of the shared unit.
// aresetn synchronous: config registers to 1 and 1229, sample count zero.
// No clearing pass: the first row of the pair pass reads the run store as zero.
// ----------------------------------------------------------------------------
// sample_entropy_engine_unit
// Sample entropy of a loaded series, one result per template order.
// ----------------------------------------------------------------------------
module sample_entropy_engine_unit
    import sen_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int MAX_ORDER   = MAX_ORDER_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire sen_in_t     s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output sen_out_t         m_data
);

    localparam int LOG_N  = $clog2(MAX_SAMPLES);
    localparam int IDX_W  = LOG_N;
    localparam int NCNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int CNT_W  = 2*LOG_N - 1;
    localparam int RUN_W  = $clog2(MAX_ORDER + 1);
    localparam int EW     = $clog2(CNT_W + 1);
    localparam int LW     = EW + FRAC_BITS;
    localparam int PW     = (LW + 31 > 55) ? LW + 31 : 55;

    typedef enum logic [8:0] {
        S_LOAD = 9'b000000001,
        S_ROW  = 9'b000000010,
        S_PAIR = 9'b000000100,
        S_RES  = 9'b000001000,
        S_LOGD = 9'b000010000,
        S_LOGN = 9'b000100000,
        S_MUL  = 9'b001000000,
        S_FIN  = 9'b010000000,
        S_OUT  = 9'b100000000
    } sen_state_t;

    sen_state_t state_reg, state_next;

    // configuration
    logic [2:0]  embed_reg;
    logic [14:0] tol_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            embed_reg <= EMBED_ORDER_RST;
            tol_reg   <= TOLERANCE_RST;
        end else if (cfg_wr) begin
            case (sen_reg_idx_t'(paddr[2]))
                REG_EMBED_ORDER: embed_reg <= pwdata[2:0];
                REG_TOLERANCE:   tol_reg   <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sen_reg_idx_t'(paddr[2]))
            REG_EMBED_ORDER: prdata = {29'd0, embed_reg};
            REG_TOLERANCE:   prdata = {17'd0, tol_reg};
            default:         prdata = '0;
        endcase
    end

    // sequencer registers
    logic [NCNT_W-1:0] count_reg;
    logic [IDX_W-1:0]  i_reg, j_reg, jj_reg;
    logic [RUN_W-1:0]  runmax_reg, m_reg;
    logic [RUN_W-1:0]  order_eff;
    logic              s_acc, m_acc, row_done, pair_end;

    assign s_ready  = (state_reg == S_LOAD);
    assign m_valid  = (state_reg == S_OUT);
    assign s_acc    = s_valid && s_ready;
    assign m_acc    = m_valid && m_ready;
    assign row_done = (NCNT_W'(i_reg) + 1'b1) >= count_reg;
    assign pair_end = NCNT_W'(j_reg) == (count_reg - 1'b1);
    assign order_eff = (int'(embed_reg) > MAX_ORDER - 1) ? RUN_W'(MAX_ORDER - 1)
                                                         : RUN_W'(embed_reg);

    // stores
    logic signed [15:0] smp_mem [MAX_SAMPLES];
    logic [RUN_W-1:0]   run_mem [MAX_SAMPLES];
    logic signed [15:0] rd_smp_reg, yi_reg;
    logic [RUN_W-1:0]   run_rd_reg;
    logic [IDX_W-1:0]   smp_raddr;

    // pair stage 1
    logic              p_vld_reg, p_first_reg, p_lastj_reg, ld_yi_reg;
    logic [IDX_W-1:0]  p_jj_reg;
    logic signed [16:0] d_ji, d_ij;
    logic signed [17:0] tol_s;
    logic              match;
    logic [RUN_W-1:0]  run_old, run_nx;

    assign smp_raddr = (state_reg == S_ROW) ? i_reg : j_reg;
    assign d_ji      = 17'(rd_smp_reg) - 17'(yi_reg);
    assign d_ij      = 17'(yi_reg) - 17'(rd_smp_reg);
    assign tol_s     = {3'b000, tol_reg};
    assign match     = (18'(d_ji) < tol_s) && (18'(d_ij) < tol_s);
    assign run_old   = p_first_reg ? '0 : run_rd_reg;
    assign run_nx    = !match ? '0 :
                       (run_old >= runmax_reg) ? runmax_reg : run_old + 1'b1;

    always_ff @(posedge aclk) begin
        if (s_acc && (count_reg < NCNT_W'(MAX_SAMPLES)))
            smp_mem[count_reg[IDX_W-1:0]] <= s_data.sample;
        rd_smp_reg <= smp_mem[smp_raddr];
    end

    always_ff @(posedge aclk) begin
        if (p_vld_reg)
            run_mem[p_jj_reg] <= run_nx;
        run_rd_reg <= run_mem[jj_reg];
    end

    always_ff @(posedge aclk) begin
        if (ld_yi_reg)
            yi_reg <= rd_smp_reg;
        p_jj_reg    <= jj_reg;
        p_first_reg <= (i_reg == '0);
        p_lastj_reg <= pair_end;
    end

    // match and template counters, one lane per order
    logic [CNT_W-1:0] a_cnt_reg [MAX_ORDER];
    logic [CNT_W-1:0] b_cnt_reg [MAX_ORDER];
    logic [CNT_W-1:0] pairs_reg;
    logic [2*NCNT_W-1:0] pairs_full;

    assign pairs_full = (2*NCNT_W)'(count_reg) * (2*NCNT_W)'(count_reg - 1'b1);

    always_ff @(posedge aclk) begin
        pairs_reg <= CNT_W'(pairs_full >> 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_ORDER; k++) begin
                a_cnt_reg[k] <= '0;
                b_cnt_reg[k] <= '0;
            end
        end else if (s_acc && s_data.last_sample) begin
            for (int k = 0; k < MAX_ORDER; k++) begin
                a_cnt_reg[k] <= '0;
                b_cnt_reg[k] <= '0;
            end
        end else if (p_vld_reg) begin
            for (int k = 0; k < MAX_ORDER; k++) begin
                if (k < int'(run_nx)) begin
                    a_cnt_reg[k] <= a_cnt_reg[k] + 1'b1;
                    if (!p_lastj_reg)
                        b_cnt_reg[k] <= b_cnt_reg[k] + 1'b1;
                end
            end
        end else if (m_acc) begin
            // results walk down lane 0; B lags A by one order
            for (int k = 0; k < MAX_ORDER - 1; k++)
                a_cnt_reg[k] <= a_cnt_reg[k+1];
            a_cnt_reg[MAX_ORDER-1] <= '0;
            if (m_reg != '0) begin
                for (int k = 0; k < MAX_ORDER - 1; k++)
                    b_cnt_reg[k] <= b_cnt_reg[k+1];
                b_cnt_reg[MAX_ORDER-1] <= '0;
            end
        end
    end

    // result path
    logic [CNT_W-1:0] den_sel, num_reg;
    logic [CNT_W-1:0] lg_x;
    logic             lg_start, lg_done, undef;
    logic [LW-1:0]    lg_res, ld_reg, ln_reg, d_log;
    logic [PW-1:0]    prod_reg;
    logic [PW-35:0]   prod_hi;

    assign den_sel  = (m_reg == '0) ? pairs_reg : b_cnt_reg[0];
    assign undef    = (a_cnt_reg[0] == '0) || (den_sel == '0);
    assign lg_start = ((state_reg == S_RES) && !undef) || ((state_reg == S_LOGD) && lg_done);
    assign lg_x     = (state_reg == S_RES) ? den_sel : num_reg;
    assign d_log    = (ld_reg > ln_reg) ? ld_reg - ln_reg : '0;
    assign prod_hi  = prod_reg[PW-1:34];

    sen_log_unit #(
        .CNT_W (CNT_W),
        .EW    (EW)
    ) u_log (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lg_start),
        .x       (lg_x),
        .done    (lg_done),
        .result  (lg_res)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD: if (s_acc && s_data.last_sample) state_next = S_ROW;
            S_ROW:  state_next = row_done ? S_RES : S_PAIR;
            S_PAIR: if (pair_end) state_next = S_ROW;
            S_RES:  state_next = undef ? S_OUT : S_LOGD;
            S_LOGD: if (lg_done) state_next = S_LOGN;
            S_LOGN: if (lg_done) state_next = S_MUL;
            S_MUL:  state_next = S_FIN;
            S_FIN:  state_next = S_OUT;
            S_OUT:  if (m_acc) state_next = (m_reg == runmax_reg - 1'b1) ? S_LOAD : S_RES;
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            p_vld_reg <= 1'b0;
            ld_yi_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            p_vld_reg <= (state_reg == S_PAIR);
            ld_yi_reg <= (state_reg == S_ROW);
            if (s_acc && (count_reg < NCNT_W'(MAX_SAMPLES)))
                count_reg <= count_reg + 1'b1;
            if (m_acc && (m_reg == runmax_reg - 1'b1))
                count_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_LOAD: begin
                i_reg      <= '0;
                m_reg      <= '0;
                runmax_reg <= order_eff + 1'b1;
            end
            S_ROW: begin
                j_reg  <= i_reg + 1'b1;
                jj_reg <= '0;
            end
            S_PAIR: begin
                j_reg  <= j_reg + 1'b1;
                jj_reg <= jj_reg + 1'b1;
                if (pair_end)
                    i_reg <= i_reg + 1'b1;
            end
            S_RES: begin
                num_reg <= a_cnt_reg[0];
                m_data.order_index    <= 3'(m_reg);
                m_data.match_total    <= 19'(a_cnt_reg[0]);
                m_data.template_total <= 19'(den_sel);
                m_data.entropy_value  <= '0;
                m_data.undefined_flag <= undef;
                m_data.last_result    <= (m_reg == runmax_reg - 1'b1);
            end
            S_LOGD: if (lg_done) ld_reg <= lg_res;
            S_LOGN: if (lg_done) ln_reg <= lg_res;
            S_MUL:  prod_reg <= PW'(d_log) * PW'(LN2_Q30) + (PW'(1) << 33);
            S_FIN: begin
                m_data.entropy_value <= (prod_hi > (PW-34)'(20'hFFFFF)) ? 20'hFFFFF
                                                                        : prod_hi[19:0];
            end
            S_OUT: if (m_acc) m_reg <= m_reg + 1'b1;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/sen_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sen_checker
// Port-level checks on the sample entropy engine, bound to the top level.
// ----------------------------------------------------------------------------
module sen_checker
    import sen_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire sen_out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word dropped or changed while stalled");

    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("loading while results pending");

    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last_result |=> s_ready && !m_valid)
        else $error("no return to loading after final result");

    a_undef_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.undefined_flag |-> m_data.entropy_value == 20'd0)
        else $error("undefined result carries a value");

    a_ratio: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.match_total <= m_data.template_total)
        else $error("match count above template count");

endmodule

bind sample_entropy_engine_unit sen_checker u_sen_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
